>>> rtl/zero_order_hold_resampler_top_assert.svh
`ifndef ZERO_ORDER_HOLD_RESAMPLER_TOP_ASSERT_SVH
`define ZERO_ORDER_HOLD_RESAMPLER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ZOHR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zohr assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ZOHR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zohr assertion failed");

`endif

>>> rtl/zohr_pkg.sv
package zohr_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned RATE_W     = 18;
    localparam int unsigned PHASE_W    = 19;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned MAX_REPEAT = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [RATE_W-1:0] FROM_RATE_RST = 18'd31440;
    localparam logic [RATE_W-1:0] TO_RATE_RST   = 18'd48000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FROM_RATE     = 2'd0,
        REG_TO_RATE       = 2'd1,
        REG_SOURCE_STEREO = 2'd2,
        REG_OUTPUT_STEREO = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } alu_op_t;

endpackage

>>> rtl/zohr_alu.sv
module zohr_alu (
    input  logic [zohr_pkg::PHASE_W-1:0] a,
    input  logic [zohr_pkg::PHASE_W-1:0] b,
    input  zohr_pkg::alu_op_t            op,
    output logic [zohr_pkg::PHASE_W-1:0] result,
    output logic                         borrow
);

    logic                         is_sub;
    logic [zohr_pkg::PHASE_W-1:0] b_op;
    logic [zohr_pkg::PHASE_W:0]   sum;

    assign is_sub = (op == zohr_pkg::OP_SUB);
    assign b_op   = is_sub ? ~b : b;
    // subtract as a + ~b + 1, carry out low means a < b
    assign sum    = {1'b0, a} + {1'b0, b_op} + {{zohr_pkg::PHASE_W{1'b0}}, is_sub};
    assign result = sum[zohr_pkg::PHASE_W-1:0];
    assign borrow = is_sub && !sum[zohr_pkg::PHASE_W];

endmodule

>>> rtl/zero_order_hold_resampler_top.sv
// Zero-order-hold resampler: each source frame accepted on the s_ side yields zero to
// 64 output frames on the m_ side, the last of them flagged by m_tlast; a frame that
// yields none produces no transfer at all. One 19-bit adder/subtractor is shared under
// a small sequencer, which uses it in turn for the phase test and the phase advance;
// s_tready is high only while the sequencer is idle, so it stays low while an item is
// in progress. One output register sits on the m_ side, so a finished frame waits
// there while the block continues.
// Configuration writes are meant for idle periods only.
module zero_order_hold_resampler_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // in_left, in_right
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // out_left, out_right
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [zohr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [zohr_pkg::RATE_W-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TEST = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                               state_reg, state_next;
    logic [zohr_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic [zohr_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic                                 pend_reg, pend_next;
    logic                                 out_valid_reg, out_valid_next;

    logic [zohr_pkg::RATE_W-1:0]          from_rate_reg;
    logic [zohr_pkg::RATE_W-1:0]          to_rate_reg;
    logic                                 source_stereo_reg;
    logic                                 output_stereo_reg;

    logic signed [zohr_pkg::SAMPLE_W-1:0] frame_left_reg;
    logic signed [zohr_pkg::SAMPLE_W-1:0] frame_right_reg;
    logic signed [zohr_pkg::SAMPLE_W-1:0] out_left_reg;
    logic signed [zohr_pkg::SAMPLE_W-1:0] out_right_reg;
    logic                                 out_last_reg;

    logic signed [zohr_pkg::SAMPLE_W-1:0] in_left;
    logic signed [zohr_pkg::SAMPLE_W-1:0] in_right;
    logic signed [zohr_pkg::SAMPLE_W:0]   mix_sum;
    logic signed [zohr_pkg::SAMPLE_W-1:0] map_left;
    logic signed [zohr_pkg::SAMPLE_W-1:0] map_right;

    zohr_pkg::alu_op_t                    alu_op;
    logic [zohr_pkg::PHASE_W-1:0]         alu_b;
    logic [zohr_pkg::PHASE_W-1:0]         alu_result;
    logic                                 alu_borrow;

    logic                                 in_xfer;
    logic                                 out_free;
    logic                                 go;
    logic                                 load_out;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // channel mapping
    assign in_left   = s_tdata[15:0];
    assign in_right  = s_tdata[31:16];
    assign mix_sum   = {in_left[zohr_pkg::SAMPLE_W-1], in_left}
                     + {in_right[zohr_pkg::SAMPLE_W-1], in_right};
    assign map_left  = (source_stereo_reg && !output_stereo_reg)
                     ? mix_sum[zohr_pkg::SAMPLE_W:1] : in_left;
    assign map_right = !output_stereo_reg ? '0 : (source_stereo_reg ? in_right : in_left);

    // shared phase unit: subtract to test phase against to_rate, add to advance
    assign alu_op = (state_reg == ST_EMIT) ? zohr_pkg::OP_ADD : zohr_pkg::OP_SUB;
    assign alu_b  = (state_reg == ST_EMIT) ? {1'b0, from_rate_reg} : {1'b0, to_rate_reg};

    zohr_alu u_alu (
        .a      (phase_reg),
        .b      (alu_b),
        .op     (alu_op),
        .result (alu_result),
        .borrow (alu_borrow)
    );

    assign go       = alu_borrow && (count_reg < zohr_pkg::COUNT_W'(zohr_pkg::MAX_REPEAT));
    assign load_out = (state_reg == ST_TEST) && pend_reg && out_free;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_TEST;
                    count_next = '0;
                    pend_next  = 1'b0;
                end
            end
            ST_TEST:
            begin
                if (!pend_reg || out_free)
                begin
                    pend_next = 1'b0;
                    if (go)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        // run capped with phase still low: clamp at zero
                        phase_next = alu_borrow ? '0 : alu_result;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                phase_next = alu_result;
                count_next = count_reg + zohr_pkg::COUNT_W'(1);
                pend_next  = 1'b1;
                state_next = ST_TEST;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            from_rate_reg     <= zohr_pkg::FROM_RATE_RST;
            to_rate_reg       <= zohr_pkg::TO_RATE_RST;
            source_stereo_reg <= 1'b1;
            output_stereo_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (zohr_pkg::cfg_reg_t'(cfg_index))
                zohr_pkg::REG_FROM_RATE:     from_rate_reg     <= cfg_data;
                zohr_pkg::REG_TO_RATE:       to_rate_reg       <= cfg_data;
                zohr_pkg::REG_SOURCE_STEREO: source_stereo_reg <= cfg_data[0];
                zohr_pkg::REG_OUTPUT_STEREO: output_stereo_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            frame_left_reg  <= map_left;
            frame_right_reg <= map_right;
        end
        if (load_out)
        begin
            out_left_reg  <= frame_left_reg;
            out_right_reg <= frame_right_reg;
            out_last_reg  <= !go;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/zohr_checker.sv
`include "zero_order_hold_resampler_top_assert.svh"

module zohr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // busy right after taking a source frame
    `ZOHR_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)

    // a stalled output frame holds
    `ZOHR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // the final frame of a run is still to come, so no new source frame is taken
    `ZOHR_ASSERT_SAME(a_no_in_mid_run, m_tvalid && m_tready && !m_tlast, !s_tready)

endmodule

bind zero_order_hold_resampler_top zohr_checker u_checker (.*);
